### sv/dwpi_pkg.sv
// Package for the dual-wheel PI speed controller.
// Holds field types, register codes, reset constants and the control struct.
// No dependencies.
package dwpi_pkg;

  localparam int unsigned BitCount  = 64;
  localparam int unsigned BitW      = $clog2(BitCount);
  localparam int unsigned DriveW    = 32;
  localparam int unsigned CountW    = 16;
  localparam int unsigned GainW     = 16;
  localparam int unsigned SetW      = 10;
  localparam int unsigned TickW     = 9;
  localparam int unsigned CfgIdxW   = 3;

  typedef logic signed [CountW-1:0] count_t;
  typedef logic signed [DriveW-1:0] drive_t;
  typedef logic        [GainW-1:0]  gain_t;
  typedef logic        [SetW-1:0]   setp_t;
  typedef logic        [TickW-1:0]  tick_t;

  localparam gain_t  KpReset        = 16'd6711;
  localparam gain_t  KiReset        = 16'd336;
  localparam tick_t  TickLimitReset = 9'd500;
  localparam drive_t LeftStartRst   = 32'sd5033165;
  localparam drive_t RightStartRst  = 32'sd5200937;
  localparam drive_t DriveMax       = 32'sh7FFF_FFFF;
  localparam drive_t DriveMin       = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP_GAIN     = 3'd0,
    REG_KI_GAIN     = 3'd1,
    REG_TICK_LIMIT  = 3'd2,
    REG_LEFT_START  = 3'd3,
    REG_RIGHT_START = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WB
  } state_e;

  typedef struct packed {
    logic load;
    logic run;
    logic lo;
    logic at31;
    logic last;
    logic clr_start;
    logic clr_end;
  } wheel_ctrl_t;

endpackage

### sv/dwpi_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on dwpi_pkg.
interface dwpi_in_if;
  logic            valid;
  logic            ready;
  dwpi_pkg::count_t left_count;
  dwpi_pkg::count_t right_count;
  dwpi_pkg::setp_t  setpoint;
  logic            clear_integral;

  modport source (output valid, left_count, right_count, setpoint, clear_integral,
                  input ready);
  modport sink   (input valid, left_count, right_count, setpoint, clear_integral,
                  output ready);
endinterface

interface dwpi_out_if;
  logic            valid;
  logic            ready;
  dwpi_pkg::drive_t left_drive;
  dwpi_pkg::drive_t right_drive;
  logic            saturated;

  modport source (output valid, left_drive, right_drive, saturated, input ready);
  modport sink   (input valid, left_drive, right_drive, saturated, output ready);
endinterface

### sv/dwpi_ser_mul.sv
// Serial-parallel multiplier: parallel gain times an LSB-first serial operand.
// Emits the product LSB-first, one bit per enabled cycle. Depends on dwpi_pkg.
module dwpi_ser_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  en_i,
  input  dwpi_pkg::gain_t       k_i,
  input  logic                  b_i,
  output logic                  p_o
);
  import dwpi_pkg::*;

  logic [GainW-1:0] acc_q, acc_d;
  logic [GainW:0]   sum;

  assign sum   = {1'b0, acc_q} + (b_i ? {1'b0, k_i} : '0);
  assign p_o   = sum[0];
  assign acc_d = sum[GainW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clr_i) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

### sv/dwpi_wheel.sv
// Bit-serial datapath of one wheel: running total, both errors, PI correction
// and saturating drive update. Depends on dwpi_pkg and dwpi_ser_mul.
module dwpi_wheel (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dwpi_pkg::wheel_ctrl_t  ctrl_i,
  input  dwpi_pkg::count_t       count_i,
  input  dwpi_pkg::drive_t       spd_i,
  input  dwpi_pkg::gain_t        kp_i,
  input  dwpi_pkg::gain_t        ki_i,
  input  logic                   sp_bit_i,
  input  logic                   p_bit_i,
  output dwpi_pkg::drive_t       nxt_o,
  output logic                   sat_o
);
  import dwpi_pkg::*;

  logic [CountW-1:0] cnt_q;
  logic [DriveW-1:0] tot_q, spd_sh_q, res_q;
  logic cy_t_q, cy_p_q, cy_i_q, cy_c_q, cy_n_q;
  logic tsign_q, b31_q, ovf_q;

  logic c, t, s, tn, ep, ei, m1, m2, co, nx, ovf_fin;

  assign c  = cnt_q[0];
  assign t  = tot_q[0];
  assign s  = spd_sh_q[0];
  assign tn = ctrl_i.lo ? (t ^ c ^ cy_t_q) : tsign_q;
  assign ep = sp_bit_i ^ ~c ^ cy_p_q;
  assign ei = p_bit_i ^ ~tn ^ cy_i_q;
  assign co = m1 ^ m2 ^ cy_c_q;
  assign nx = s ^ co ^ cy_n_q;

  dwpi_ser_mul u_mul_p (
    .clk_i, .rst_ni, .clr_i(ctrl_i.load), .en_i(ctrl_i.run),
    .k_i(kp_i), .b_i(ep), .p_o(m1)
  );

  dwpi_ser_mul u_mul_i (
    .clk_i, .rst_ni, .clr_i(ctrl_i.load), .en_i(ctrl_i.run),
    .k_i(ki_i), .b_i(ei), .p_o(m2)
  );

  assign ovf_fin = ovf_q | (nx != b31_q);
  assign nxt_o   = ovf_fin ? (nx ? DriveMin : DriveMax) : drive_t'(res_q);
  assign sat_o   = ovf_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= '0;
      cy_t_q <= 1'b0;
      cy_p_q <= 1'b1;
      cy_i_q <= 1'b1;
      cy_c_q <= 1'b0;
      cy_n_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (ctrl_i.load) begin
      if (ctrl_i.clr_start) begin
        tot_q <= '0;
      end
      cy_t_q <= 1'b0;
      cy_p_q <= 1'b1;
      cy_i_q <= 1'b1;
      cy_c_q <= 1'b0;
      cy_n_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (ctrl_i.run) begin
      if (ctrl_i.lo) begin
        tot_q  <= {tn, tot_q[DriveW-1:1]};
        cy_t_q <= (t & c) | (t & cy_t_q) | (c & cy_t_q);
      end else begin
        ovf_q <= ovf_q | (nx != b31_q);
      end
      if (ctrl_i.last && ctrl_i.clr_end) begin
        tot_q <= '0;
      end
      cy_p_q <= (sp_bit_i & ~c) | (sp_bit_i & cy_p_q) | (~c & cy_p_q);
      cy_i_q <= (p_bit_i & ~tn) | (p_bit_i & cy_i_q) | (~tn & cy_i_q);
      cy_c_q <= (m1 & m2) | (m1 & cy_c_q) | (m2 & cy_c_q);
      cy_n_q <= (s & co) | (s & cy_n_q) | (co & cy_n_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cnt_q    <= count_i;
      spd_sh_q <= spd_i;
    end else if (ctrl_i.run) begin
      cnt_q    <= {cnt_q[CountW-1], cnt_q[CountW-1:1]};
      spd_sh_q <= {spd_sh_q[DriveW-1], spd_sh_q[DriveW-1:1]};
      if (ctrl_i.lo) begin
        res_q <= {nx, res_q[DriveW-1:1]};
      end
      if (ctrl_i.at31) begin
        tsign_q <= tn;
        b31_q   <= nx;
      end
    end
  end

endmodule

### sv/dual_wheel_pi_speed_control_top.sv
// Dual-wheel incremental PI speed controller, top level. Depends on dwpi_pkg,
// dwpi_if, dwpi_ser_mul and dwpi_wheel. An accepted request runs a bit-serial
// pass through the tick product and per-wheel PI datapaths, then a writeback,
// which waits while the previous result is unread. A new request is taken only
// in the idle state, after the pass and writeback of the previous one.
// Reset: gains, tick limit and drives take defaults, counter and totals clear.
module dual_wheel_pi_speed_control_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  dwpi_in_if.sink                  in_i,
  dwpi_out_if.source               out_o,
  input  logic                     cfg_we_i,
  input  logic [dwpi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dwpi_pkg::DriveW-1:0]  cfg_data_i
);
  import dwpi_pkg::*;

  localparam logic [BitW-1:0] BitLast = BitW'(BitCount - 1);
  localparam logic [BitW-1:0] Bit31   = BitW'(31);

  state_e state_q, state_d;
  logic [BitW-1:0] bit_q;
  gain_t  kp_q, ki_q;
  tick_t  limit_q, tc_q;
  logic [TickW:0] ticks_q;
  logic [SetW-1:0] sp_sh_q;
  drive_t left_spd_q, right_spd_q;
  logic   sat_q;
  drive_t out_left_q, out_right_q;
  logic   out_sat_q, out_valid_q;

  logic accept, last, p_bit, l_sat, r_sat, wb_go;
  drive_t l_nxt, r_nxt;
  wheel_ctrl_t ctrl;

  assign accept = in_i.valid && in_i.ready;
  assign last   = (state_q == ST_RUN) && (bit_q == BitLast);
  assign wb_go  = (state_q == ST_WB) && (!out_valid_q || out_o.ready);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    ctrl.load      = accept;
    ctrl.run       = (state_q == ST_RUN);
    ctrl.lo        = !bit_q[BitW-1];
    ctrl.at31      = (bit_q == Bit31);
    ctrl.last      = last;
    ctrl.clr_start = in_i.clear_integral;
    ctrl.clr_end   = ticks_q > {1'b0, limit_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_RUN;
      ST_RUN:  if (last) state_d = ST_WB;
      ST_WB:   if (wb_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  dwpi_ser_mul u_mul_tick (
    .clk_i, .rst_ni, .clr_i(accept), .en_i(ctrl.run),
    .k_i(GainW'(ticks_q)), .b_i(sp_sh_q[0]), .p_o(p_bit)
  );

  dwpi_wheel u_left (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .count_i(in_i.left_count), .spd_i(left_spd_q),
    .kp_i(kp_q), .ki_i(ki_q), .sp_bit_i(sp_sh_q[0]), .p_bit_i(p_bit),
    .nxt_o(l_nxt), .sat_o(l_sat)
  );

  dwpi_wheel u_right (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .count_i(in_i.right_count), .spd_i(right_spd_q),
    .kp_i(kp_q), .ki_i(ki_q), .sp_bit_i(sp_sh_q[0]), .p_bit_i(p_bit),
    .nxt_o(r_nxt), .sat_o(r_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= KpReset;
      ki_q        <= KiReset;
      limit_q     <= TickLimitReset;
      left_spd_q  <= LeftStartRst;
      right_spd_q <= RightStartRst;
      tc_q        <= '0;
      bit_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KP_GAIN:     kp_q        <= cfg_data_i[GainW-1:0];
          REG_KI_GAIN:     ki_q        <= cfg_data_i[GainW-1:0];
          REG_TICK_LIMIT:  limit_q     <= cfg_data_i[TickW-1:0];
          REG_LEFT_START:  left_spd_q  <= drive_t'(cfg_data_i);
          REG_RIGHT_START: right_spd_q <= drive_t'(cfg_data_i);
          default: ;
        endcase
      end
      if (accept) begin
        bit_q <= '0;
      end else if (ctrl.run) begin
        bit_q <= bit_q + 1'b1;
      end
      if (last) begin
        left_spd_q  <= l_nxt;
        right_spd_q <= r_nxt;
        sat_q       <= l_sat | r_sat;
        tc_q        <= ctrl.clr_end ? '0 : ticks_q[TickW-1:0];
      end
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ticks_q <= (in_i.clear_integral ? '0 : {1'b0, tc_q}) + 1'b1;
      sp_sh_q <= in_i.setpoint;
    end else if (ctrl.run) begin
      sp_sh_q <= {1'b0, sp_sh_q[SetW-1:1]};
    end
    if (wb_go) begin
      out_left_q  <= left_spd_q;
      out_right_q <= right_spd_q;
      out_sat_q   <= sat_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_drive  = out_left_q;
  assign out_o.right_drive = out_right_q;
  assign out_o.saturated   = out_sat_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready) else $error("ready while busy");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN) && (bit_q == '0)) else $error("bad pass start");

  a_last_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |=> (state_q == ST_WB)) else $error("pass did not end in writeback");

  a_valid_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_WB)) else $error("stray result");

endmodule

### dv/tb_top.sv
// Self-checking testbench for dual_wheel_pi_speed_control_top.
// Random and directed control ticks are checked against a cycle-free model of the PI update.
// Depends on dwpi_pkg, dwpi_if and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dwpi_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 70;
  localparam int LongHoldCycles = 400;
  localparam int MaxPrinted = 50;
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  typedef struct packed {
    count_t left_count;
    count_t right_count;
    setp_t  setpoint;
    logic   clear_integral;
  } tick_req_t;

  typedef struct packed {
    drive_t left_drive;
    drive_t right_drive;
    logic   saturated;
  } drive_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DriveW-1:0] cfg_data;

  dwpi_in_if  in_ch ();
  dwpi_out_if out_ch ();

  dual_wheel_pi_speed_control_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // controller model state
  gain_t  ctl_kp;
  gain_t  ctl_ki;
  tick_t  ctl_tick_lim;
  tick_t  tick_cnt;
  logic [31:0] left_total;
  logic [31:0] right_total;
  drive_t left_acc;
  drive_t right_acc;

  tick_req_t     pending_ticks[$];
  drive_result_t expected_drives[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles = 0;
  logic in_taken = 1'b0;
  int cycle_count = 0;
  int fail_count = 0;
  int reqs_seen = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int cfg_writes = 0;

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxPrinted) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  function automatic drive_t next_drive(input drive_t drive, input logic [31:0] total,
                                        input count_t cnt, input setp_t sp,
                                        input logic [TickW:0] ticks, output logic clip);
    longint err_p, err_i, corr, sum;
    err_p = longint'(sp) - longint'(cnt);
    err_i = longint'(sp) * longint'(ticks) - longint'($signed(total));
    corr = longint'(ctl_kp) * err_p + longint'(ctl_ki) * err_i;
    sum = longint'(drive) + corr;
    clip = 1'b0;
    if (sum > longint'(DriveMax)) begin
      sum = longint'(DriveMax);
      clip = 1'b1;
    end else if (sum < longint'(DriveMin)) begin
      sum = longint'(DriveMin);
      clip = 1'b1;
    end
    return drive_t'(sum);
  endfunction

  function automatic drive_result_t advance_pi_tick(input tick_req_t r);
    drive_result_t res;
    logic [TickW:0] ticks;
    logic clip_l, clip_r;
    if (r.clear_integral) begin
      tick_cnt = '0;
      left_total = '0;
      right_total = '0;
    end
    ticks = {1'b0, tick_cnt} + 1'b1;
    left_total = left_total + {{16{r.left_count[15]}}, r.left_count};
    right_total = right_total + {{16{r.right_count[15]}}, r.right_count};
    right_acc = next_drive(right_acc, right_total, r.right_count, r.setpoint, ticks, clip_r);
    left_acc = next_drive(left_acc, left_total, r.left_count, r.setpoint, ticks, clip_l);
    if (ticks > {1'b0, ctl_tick_lim}) begin
      tick_cnt = '0;
      left_total = '0;
      right_total = '0;
    end else begin
      tick_cnt = ticks[TickW-1:0];
    end
    res.left_drive = left_acc;
    res.right_drive = right_acc;
    res.saturated = clip_l | clip_r;
    return res;
  endfunction

  function automatic tick_req_t mk(input int lc, input int rc, input int sp, input bit clr);
    tick_req_t r;
    r.left_count = count_t'(lc);
    r.right_count = count_t'(rc);
    r.setpoint = setp_t'(sp);
    r.clear_integral = clr;
    return r;
  endfunction

  function automatic count_t pick_count(input int sp, input int sel);
    if (sel < 60) begin
      return count_t'(sp + $urandom_range(40) - 20);
    end else if (sel < 85) begin
      return count_t'($urandom());
    end
    case ($urandom_range(3))
      0: return count_t'(-32768);
      1: return count_t'(32767);
      2: return count_t'(-1);
      default: return count_t'(0);
    endcase
  endfunction

  // mostly counts that track the setpoint, the rest wild
  function automatic tick_req_t make_request(input int clear_pct);
    int sp;
    int sel;
    if ($urandom_range(9) == 0) begin
      sp = $urandom_range(1) ? 1023 : 0;
    end else begin
      sp = $urandom_range(1023);
    end
    sel = $urandom_range(99);
    return mk(pick_count(sp, sel), pick_count(sp, sel), sp,
              $urandom_range(99) < clear_pct);
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [31:0] data;
    data = $urandom();
    case ($urandom_range(3))
      0: data[15:0] = 16'hFFFF;
      1: data[15:0] = 16'($urandom());
      default: data[15:0] = 16'($urandom_range(8000));
    endcase
    return data;
  endfunction

  function automatic logic [31:0] limit_word(input int lim);
    logic [31:0] data;
    data = $urandom();
    data[TickW-1:0] = tick_t'(lim);
    return data;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      REG_KP_GAIN:     ctl_kp = data[GainW-1:0];
      REG_KI_GAIN:     ctl_ki = data[GainW-1:0];
      REG_TICK_LIMIT:  ctl_tick_lim = data[TickW-1:0];
      REG_LEFT_START:  left_acc = drive_t'(data);
      REG_RIGHT_START: right_acc = drive_t'(data);
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_ch.valid || expected_drives.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_phase(input int n, input int clear_pct, input bit pause_midway);
    for (int i = 0; i < n; i++) begin
      pending_ticks.push_back(make_request(clear_pct));
      if (pause_midway && i == n / 2) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  // request driver
  always @(negedge clk_i) begin
    tick_req_t nxt;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pending_ticks.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.left_count <= nxt.left_count;
        in_ch.right_count <= nxt.right_count;
        in_ch.setpoint <= nxt.setpoint;
        in_ch.clear_integral <= nxt.clear_integral;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready, with an optional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    tick_req_t req;
    drive_result_t want;
    if (rst_ni) begin
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        req.left_count = in_ch.left_count;
        req.right_count = in_ch.right_count;
        req.setpoint = in_ch.setpoint;
        req.clear_integral = in_ch.clear_integral;
        expected_drives.push_back(advance_pi_tick(req));
        reqs_seen++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.saturated) sat_seen++;
        if (expected_drives.size() == 0) begin
          note_failure($sformatf("result %0d arrived with no request pending", results_seen));
        end else begin
          want = expected_drives.pop_front();
          if (out_ch.left_drive !== want.left_drive) begin
            note_failure($sformatf("result %0d left_drive got %0d want %0d",
                                   results_seen, out_ch.left_drive, want.left_drive));
          end
          if (out_ch.right_drive !== want.right_drive) begin
            note_failure($sformatf("result %0d right_drive got %0d want %0d",
                                   results_seen, out_ch.right_drive, want.right_drive));
          end
          if (out_ch.saturated !== want.saturated) begin
            note_failure($sformatf("result %0d saturated got %b want %b",
                                   results_seen, out_ch.saturated, want.saturated));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.left_count = '0;
    in_ch.right_count = '0;
    in_ch.setpoint = '0;
    in_ch.clear_integral = 1'b0;
    out_ch.ready = 1'b0;
    ctl_kp = KpReset;
    ctl_ki = KiReset;
    ctl_tick_lim = TickLimitReset;
    tick_cnt = '0;
    left_total = '0;
    right_total = '0;
    left_acc = LeftStartRst;
    right_acc = RightStartRst;
    tx_idle_pct = 38;
    rx_idle_pct = 74;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // field extremes at reset gains, then a run into positive saturation
    pending_ticks.push_back(mk(0, 0, 0, 1));
    pending_ticks.push_back(mk(32767, 32767, 1023, 0));
    pending_ticks.push_back(mk(-32768, -32768, 1023, 0));
    pending_ticks.push_back(mk(-32768, 32767, 0, 0));
    pending_ticks.push_back(mk(32767, -32768, 512, 1));
    pending_ticks.push_back(mk(-1, -1, 1023, 0));
    pending_ticks.push_back(mk(100, 95, 100, 0));
    for (int i = 0; i < 5; i++) pending_ticks.push_back(mk(-32768, -32768, 1023, 0));
    wait_drained();

    // full-scale gains from opposite rails
    write_reg(REG_KP_GAIN, 32'h0000_FFFF);
    write_reg(REG_KI_GAIN, 32'h0000_FFFF);
    write_reg(REG_LEFT_START, DriveMin);
    write_reg(REG_RIGHT_START, DriveMax);
    pending_ticks.push_back(mk(-32768, 32767, 1023, 1));
    pending_ticks.push_back(mk(-32768, 32767, 1023, 0));
    pending_ticks.push_back(mk(32767, -32768, 0, 0));
    pending_ticks.push_back(mk(32767, -32768, 0, 0));
    wait_drained();

    // zero gains hold the drives
    write_reg(REG_KP_GAIN, 32'h0);
    write_reg(REG_KI_GAIN, 32'h0);
    pending_ticks.push_back(mk(12345, -12345, 777, 0));
    wait_drained();

    // tick limit zero clears every tick; a spare index must do nothing
    write_reg(REG_KP_GAIN, 32'(KpReset));
    write_reg(REG_KI_GAIN, 32'(KiReset));
    write_reg(REG_TICK_LIMIT, 32'h0);
    write_reg(RegSpare, $urandom());
    pending_ticks.push_back(mk(10, 20, 300, 0));
    pending_ticks.push_back(mk(10, 20, 300, 0));
    wait_drained();

    // limit lowered below the running count
    write_reg(REG_TICK_LIMIT, limit_word(10));
    for (int i = 0; i < 5; i++) pending_ticks.push_back(mk(50, 60, 300, 0));
    wait_drained();
    write_reg(REG_TICK_LIMIT, limit_word(2));
    pending_ticks.push_back(mk(50, 60, 300, 0));
    pending_ticks.push_back(mk(50, 60, 300, 0));
    wait_drained();

    // random gains and starts, sender pauses halfway
    write_reg(REG_KP_GAIN, pick_gain());
    write_reg(REG_KI_GAIN, pick_gain());
    write_reg(REG_TICK_LIMIT, limit_word($urandom_range(1, 511)));
    write_reg(REG_LEFT_START, $urandom());
    write_reg(REG_RIGHT_START, $urandom());
    random_phase(126, 5, 1'b1);

    write_reg(REG_KP_GAIN, pick_gain());
    write_reg(REG_KI_GAIN, pick_gain());
    write_reg(REG_TICK_LIMIT, limit_word($urandom_range(1, 20)));
    random_phase(126, 10, 1'b0);

    // swap idle ratios; long output stall backs up the input
    tx_idle_pct = 74;
    rx_idle_pct = 38;
    write_reg(REG_KP_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_KI_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_TICK_LIMIT, limit_word($urandom_range(1, 511)));
    write_reg(REG_LEFT_START, $urandom());
    write_reg(REG_RIGHT_START, $urandom());
    @(posedge clk_i);
    rx_hold_cycles = LongHoldCycles;
    random_phase(126, 5, 1'b0);

    write_reg(REG_KP_GAIN, pick_gain());
    write_reg(REG_KI_GAIN, pick_gain());
    write_reg(REG_TICK_LIMIT, limit_word(1));
    random_phase(126, 20, 1'b0);

    // no idling; top limit with no clears so the counter reaches 512
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_KP_GAIN, 32'($urandom_range(8000)));
    write_reg(REG_KI_GAIN, 32'($urandom_range(500)));
    write_reg(REG_TICK_LIMIT, limit_word(511));
    write_reg(REG_LEFT_START, LeftStartRst);
    write_reg(REG_RIGHT_START, RightStartRst);
    random_phase(520, 0, 1'b0);

    repeat (DrainCycles) @(negedge clk_i);
    if (expected_drives.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_drives.size()));
    end
    $display("Summary: %0d requests, %0d results checked, %0d saturated, %0d register writes",
             reqs_seen, results_seen, sat_seen, cfg_writes);
    $display("Covered gain and start rails, tick limits 0/1/511, a %0d-cycle output stall",
             LongHoldCycles);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
